// ----- design/uartrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_pkg
// shared types and constants of the serial port receive and transmit fifos
// ----------------------------------------------------------------------------
package uartrb_pkg;

    // default ring depth, one slot always stays empty
    localparam int FIFO_DEPTH_DEF = 64;

    // stream widths
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 40;
    localparam int STAT_W     = 6;

    // request kinds carried on tuser
    typedef enum logic [IN_USER_W-1:0] {
        KIND_RX_BYTE    = 3'd0,
        KIND_TX_READY   = 3'd1,
        KIND_HOST_WRITE = 3'd2,
        KIND_HOST_READ  = 3'd3,
        KIND_HOST_PEEK  = 3'd4
    } t_kind;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic execute;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

// ----- design/uartrb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module uartrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/uartrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_ctrl
// sequencer: takes a request, waits for the ram read, then executes it
// ----------------------------------------------------------------------------
module uartrb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  uartrb_pkg::t_status i_status,
    output uartrb_pkg::t_cmd    o_cmd
);
    import uartrb_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.capture  = 1'b0;
        o_cmd.execute  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // no request is taken while reset is held
                o_cmd.in_ready = i_rst_n;
                if (i_rst_n && i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold here while the result register is still occupied
                if (!i_status.out_busy) begin
                    o_cmd.execute = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/uartrb_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uartrb_dpath
// ring indices, fifo stores, request decode and result register
// ----------------------------------------------------------------------------
module uartrb_dpath #(
    parameter int FIFO_DEPTH = uartrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  uartrb_pkg::t_cmd                   i_cmd,
    output uartrb_pkg::t_status                o_status,
    input  logic [uartrb_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [uartrb_pkg::IN_USER_W-1:0]   i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [uartrb_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import uartrb_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);
    localparam int SW = (IW + 1 > STAT_W) ? IW + 1 : STAT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(FIFO_DEPTH - 1);
    localparam logic [IW:0]   DEPTH_V  = (IW + 1)'(FIFO_DEPTH);

    // step a ring index, wrapping at the depth
    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        ring_next = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // bytes held between two indices
    function automatic logic [IW-1:0] ring_used(input logic [IW-1:0] wr,
                                                input logic [IW-1:0] rd);
        logic [IW:0] diff;
        diff = {1'b0, wr} - {1'b0, rd};
        if (diff[IW]) begin
            diff = diff + DEPTH_V;
        end
        ring_used = diff[IW-1:0];
    endfunction

    // control state
    logic [IW-1:0] r_rx_wr, r_rx_rd, r_tx_wr, r_tx_rd;
    logic [IW-1:0] n_rx_wr, n_rx_rd, n_tx_wr, n_tx_rd;
    logic          r_tx_irq, n_tx_irq;
    logic          r_out_valid;

    // captured request and result payload
    t_kind                 r_kind;
    logic [7:0]            r_data;
    logic                  r_perr;
    logic                  r_treg;
    logic [OUT_DATA_W-1:0] r_out;
    logic [OUT_DATA_W-1:0] n_out;

    // ring neighbours
    logic [IW-1:0] rx_wr_nx, rx_rd_nx, tx_wr_nx, tx_rd_nx;
    assign rx_wr_nx = ring_next(r_rx_wr);
    assign rx_rd_nx = ring_next(r_rx_rd);
    assign tx_wr_nx = ring_next(r_tx_wr);
    assign tx_rd_nx = ring_next(r_tx_rd);

    // store ports
    logic       rx_we, tx_we;
    logic [7:0] rx_rdata, tx_rdata;

    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (rx_we),
        .i_wr_addr (rx_wr_nx),
        .i_wr_data (r_data),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (rx_rd_nx),
        .o_rd_data (rx_rdata)
    );

    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_tx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tx_we),
        .i_wr_addr (tx_wr_nx),
        .i_wr_data (r_data),
        .i_rd_en   (i_cmd.capture),
        .i_rd_addr (tx_rd_nx),
        .o_rd_data (tx_rdata)
    );

    // request decode
    logic          line_valid, read_valid, accepted, dropped;
    logic [7:0]    line_byte, read_byte;
    logic [IW-1:0] rx_used, tx_used, tx_free;
    logic [SW-1:0] rx_used_w, tx_free_w;

    always_comb begin
        n_rx_wr    = r_rx_wr;
        n_rx_rd    = r_rx_rd;
        n_tx_wr    = r_tx_wr;
        n_tx_rd    = r_tx_rd;
        n_tx_irq   = r_tx_irq;
        rx_we      = 1'b0;
        tx_we      = 1'b0;
        line_valid = 1'b0;
        line_byte  = 8'd0;
        read_valid = 1'b0;
        read_byte  = 8'd0;
        accepted   = 1'b0;
        dropped    = 1'b0;
        unique case (r_kind) inside
            KIND_RX_BYTE: begin
                if (r_perr || rx_wr_nx == r_rx_rd) begin
                    dropped = 1'b1;
                end else begin
                    rx_we   = i_cmd.execute;
                    n_rx_wr = rx_wr_nx;
                end
            end
            KIND_TX_READY: begin
                if (r_tx_wr != r_tx_rd) begin
                    n_tx_rd    = tx_rd_nx;
                    line_valid = 1'b1;
                    line_byte  = tx_rdata;
                end else begin
                    n_tx_irq = 1'b0;
                end
            end
            KIND_HOST_WRITE: begin
                if (r_tx_wr == r_tx_rd && r_treg) begin
                    // straight to the line
                    line_valid = 1'b1;
                    line_byte  = r_data;
                    accepted   = 1'b1;
                end else if (tx_wr_nx != r_tx_rd) begin
                    tx_we    = i_cmd.execute;
                    n_tx_wr  = tx_wr_nx;
                    n_tx_irq = 1'b1;
                    accepted = 1'b1;
                end
            end
            KIND_HOST_READ, KIND_HOST_PEEK: begin
                if (r_rx_wr != r_rx_rd) begin
                    read_valid = 1'b1;
                    read_byte  = rx_rdata;
                    if (r_kind == KIND_HOST_READ) begin
                        n_rx_rd = rx_rd_nx;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // status after this request
    assign rx_used   = ring_used(n_rx_wr, n_rx_rd);
    assign tx_used   = ring_used(n_tx_wr, n_tx_rd);
    assign tx_free   = LAST_IDX - tx_used;
    assign rx_used_w = SW'(rx_used);
    assign tx_free_w = SW'(tx_free);

    // result packing, highest field first
    assign n_out = {7'd0, dropped, accepted, n_tx_irq,
                    tx_free_w[STAT_W-1:0], rx_used_w[STAT_W-1:0],
                    read_byte, read_valid, line_byte, line_valid};

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= t_kind'(i_s_tuser);
            r_data <= i_s_tdata[7:0];
            r_perr <= i_s_tdata[8];
            r_treg <= i_s_tdata[9];
        end
    end

    // ring indices and interrupt enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr  <= '0;
            r_rx_rd  <= '0;
            r_tx_wr  <= '0;
            r_tx_rd  <= '0;
            r_tx_irq <= 1'b0;
        end else if (i_cmd.execute) begin
            r_rx_wr  <= n_rx_wr;
            r_rx_rd  <= n_rx_rd;
            r_tx_wr  <= n_tx_wr;
            r_tx_rd  <= n_tx_rd;
            r_tx_irq <= n_tx_irq;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_status.out_busy = r_out_valid & ~i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = r_out;

endmodule

// ----- design/uart_rx_tx_ring_buffers.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// receive and transmit byte fifos of an interrupt driven serial port
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one event: a byte received from the
// line, transmitter ready, or a host write, read or peek (kind on tuser).
// Every request gives exactly one result on m_axis: the byte handed to the
// transmitter, the byte read, the fifo levels, the transmit interrupt enable
// and the accept and drop flags.
// A request is taken and then executed once the registered read of the fifo
// store is back and the result register can accept it; the result is valid
// in the cycle after execution. A new request is taken only after the last
// one has executed, since each waits for that registered store read.
// The result register lets the next request be taken while a result still
// waits; if the receiver keeps m_axis_tready low, execution of that next
// request holds and s_axis_tready stays low until the result is taken.
// Reset empties both fifos and clears the interrupt enable; store contents
// are not cleared, as no slot is read before it is written.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
    parameter int FIFO_DEPTH = uartrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] data_byte, [8] parity_error, [9] tx_reg_empty, [15:10] zero
    input  logic [uartrb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [2:0] kind
    input  logic [uartrb_pkg::IN_USER_W-1:0]   s_axis_tuser,
    // result channel
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] line_valid, [8:1] line_byte, [9] read_valid, [17:10] read_byte,
    // [23:18] rx_count, [29:24] tx_free, [30] tx_irq_on,
    // [31] write_accepted, [32] rx_dropped, [39:33] zero
    output logic [uartrb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import uartrb_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer
    uartrb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // fifos and result register
    uartrb_dpath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule
